### design/i64div_pkg.sv
// ----------------------------------------------------------------------------
// i64div_pkg
// Shared types for the restoring divider: controller states and the
// command and status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package i64div_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIX
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture operands and form their magnitudes.
    logic step;    // Retire one quotient bit.
    logic finish;  // Apply signs and write the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // The output register can take a new result this cycle.
  } status_t;

endpackage

### design/int64_divider.sv
// ----------------------------------------------------------------------------
// int64_divider
// Signed or unsigned truncating integer divider built as a controller and
// a restoring shift-subtract datapath.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  -----------------------------------
//   input     in_valid_i / in_ready_o    cmd_i, dividend_i, divisor_i
//   output    out_valid_o / out_ready_i  quotient_o, remainder_o,
//                                        div_by_zero_o
//
// The operand magnitudes are formed and captured at the accepting edge. The
// shift-subtract loop then retires the quotient bits in turn, and a final step
// applies the signs and writes the output register, which raises out_valid_o.
// The controller returns to idle after that final step and only there accepts
// the next transaction, so transactions do not overlap.
// A new transaction is accepted once the previous one has reached the output
// register, even while that result still waits for out_ready_i.
// If the output register is still occupied when a result is finished, the
// controller holds the finished result until the register frees up.
// Reset is asynchronous and active low; it empties the output register and
// returns the controller to idle.
//
// Only the low WIDTH bits of the operands are used. Results are WIDTH-bit
// patterns with zero above. In signed mode the quotient is negated when the
// operand signs differ and the remainder takes the dividend's sign. A zero
// divisor raises div_by_zero_o with quotient and remainder returned as zero.
// The most negative value divided by minus one wraps to itself.
// ----------------------------------------------------------------------------
module int64_divider #(
  parameter int WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] quotient_o,
  output logic [63:0] remainder_o,
  output logic        div_by_zero_o
);

  i64div_pkg::cmd_t    cmd;
  i64div_pkg::status_t status;

  // The controller sequences load, iteration and finish.
  i64div_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds operands, the partial remainder and the result.
  i64div_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cmd_sel_i     (cmd_i),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .quotient_o    (quotient_o),
    .remainder_o   (remainder_o),
    .div_by_zero_o (div_by_zero_o)
  );

endmodule

### design/i64div_ctrl.sv
// ----------------------------------------------------------------------------
// i64div_ctrl
// Sequencer for the divider: accepts a transaction, counts the
// shift-subtract iterations and hands the result to the output register.
// ----------------------------------------------------------------------------
module i64div_ctrl #(
  parameter int WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i64div_pkg::status_t  status_i,
  output i64div_pkg::cmd_t     cmd_o
);

  localparam int CntW = $clog2(WIDTH);

  i64div_pkg::state_e state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i64div_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      i64div_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntW'(WIDTH - 1);
          state_d    = i64div_pkg::ST_CALC;
        end
      end
      i64div_pkg::ST_CALC: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = i64div_pkg::ST_FIX;
        end
      end
      i64div_pkg::ST_FIX: begin
        // Hold here while an earlier result still waits to be taken.
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = i64div_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i64div_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/i64div_dp.sv
// ----------------------------------------------------------------------------
// i64div_dp
// Datapath of the divider: operand magnitudes, the restoring
// shift-subtract step, sign correction and the output register.
// ----------------------------------------------------------------------------
module i64div_dp #(
  parameter int WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i64div_pkg::cmd_t     cmd_i,
  output i64div_pkg::status_t  status_o,
  input  logic                 cmd_sel_i,
  input  logic [63:0]          dividend_i,
  input  logic [63:0]          divisor_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          quotient_o,
  output logic [63:0]          remainder_o,
  output logic                 div_by_zero_o
);

  logic [WIDTH-1:0] num, den;
  logic             num_neg, den_neg;

  logic [WIDTH-1:0] den_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic             qneg_q, rneg_q, dz_q;

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             borrow;

  logic [WIDTH-1:0] res_quo, res_rem;
  logic [WIDTH-1:0] out_quo_q, out_rem_q;
  logic             out_dz_q;
  logic             out_valid_q;

  assign num     = dividend_i[WIDTH-1:0];
  assign den     = divisor_i[WIDTH-1:0];
  assign num_neg = cmd_sel_i & num[WIDTH-1];
  assign den_neg = cmd_sel_i & den[WIDTH-1];

  // For a nonzero divisor the partial remainder stays below it, so a successful trial
  // subtraction always fits back into WIDTH bits.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign borrow  = diff[WIDTH+1];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = num_neg ? (~num + 1'b1) : num;
    end else if (cmd_i.step) begin
      rem_d = borrow ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ~borrow};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.load) begin
      den_q  <= den_neg ? (~den + 1'b1) : den;
      qneg_q <= num_neg ^ den_neg;
      rneg_q <= num_neg;
      dz_q   <= (den == '0);
    end
  end

  always_comb begin
    if (dz_q) begin
      res_quo = '0;
      res_rem = '0;
    end else begin
      res_quo = qneg_q ? (~quo_q + 1'b1) : quo_q;
      res_rem = rneg_q ? (~rem_q + 1'b1) : rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_quo_q <= res_quo;
      out_rem_q <= res_rem;
      out_dz_q  <= dz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign quotient_o    = 64'(out_quo_q);
  assign remainder_o   = 64'(out_rem_q);
  assign div_by_zero_o = out_dz_q;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 64-bit restoring divider. A short table of
// corner-case divisions runs first, followed by about 750 random signed and
// unsigned divisions under three mixes of sender idling and receiver stalls.
// Each result is checked against its table answer or a model of truncating division.
// ----------------------------------------------------------------------------
module tb_top;

  // The block runs at its full 64-bit width.
  localparam int DIV_WIDTH = 64;
  // Steps from acceptance to result: magnitudes, one quotient bit per cycle, sign fix.
  localparam int DIV_LATENCY = DIV_WIDTH + 2;
  localparam int CLK_PERIOD = 4;
  // Watchdog limit for the whole run.
  localparam int unsigned TIMEOUT_CYCLES = 1_500_000;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int NUM_DIRECTED = 23;

  // Division modes on cmd_i.
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED = 1'b1;

  // Bit patterns that show up repeatedly in the corner cases.
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;

  // One finished division as it leaves the block.
  typedef struct packed {
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic        div_by_zero;
  } div_result_t;

  // One row of the corner-case table. When has_answer is set, the answer is
  // written into the row; otherwise it comes from predict_division.
  typedef struct packed {
    logic        cmd;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        has_answer;
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic        div_by_zero;
  } corner_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = CMD_UNSIGNED;
  logic [63:0] dividend_i = '0;
  logic [63:0] divisor_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] quotient_o;
  logic [63:0] remainder_o;
  logic        div_by_zero_o;

  // Results of accepted transactions that have not come out yet, oldest first.
  div_result_t pending_results[$];
  int unsigned mismatch_count = 0;

  // Current idling mix, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_left = 0;

  // Corner cases: division by zero in both modes, the signed overflow that
  // wraps, the extreme operands, and the mixed-sign and both-negative
  // combinations of a signed division.
  corner_case_t corner_cases [NUM_DIRECTED] = '{
    '{CMD_UNSIGNED, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
    '{CMD_UNSIGNED, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
    '{CMD_SIGNED, MIN_S64, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
    '{CMD_SIGNED, MIN_S64, ALL_ONES, 1'b1, MIN_S64, 64'd0, 1'b0},
    '{CMD_UNSIGNED, ALL_ONES, 64'd1, 1'b1, ALL_ONES, 64'd0, 1'b0},
    '{CMD_UNSIGNED, ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd0, 1'b0},
    '{CMD_UNSIGNED, 64'd0, ALL_ONES, 1'b1, 64'd0, 64'd0, 1'b0},
    '{CMD_UNSIGNED, 64'd1, MIN_S64, 1'b1, 64'd0, 64'd1, 1'b0},
    '{CMD_UNSIGNED, ALL_ONES, MIN_S64, 1'b1, 64'd1, MAX_S64, 1'b0},
    '{CMD_SIGNED, MIN_S64, 64'd1, 1'b1, MIN_S64, 64'd0, 1'b0},
    '{CMD_SIGNED, MIN_S64, MIN_S64, 1'b1, 64'd1, 64'd0, 1'b0},
    '{CMD_SIGNED, MAX_S64, MIN_S64, 1'b1, 64'd0, MAX_S64, 1'b0},
    '{CMD_SIGNED, ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd0, 1'b0},
    '{CMD_SIGNED, MAX_S64, ALL_ONES, 1'b1, 64'h8000_0000_0000_0001, 64'd0, 1'b0},
    '{CMD_UNSIGNED, 64'd1, 64'd1, 1'b1, 64'd1, 64'd0, 1'b0},
    '{CMD_UNSIGNED, 64'd7, 64'd2, 1'b0, 64'd0, 64'd0, 1'b0},
    '{CMD_SIGNED, 64'hffff_ffff_ffff_fff9, 64'd2, 1'b0, 64'd0, 64'd0, 1'b0},
    '{CMD_SIGNED, 64'd7, 64'hffff_ffff_ffff_fffe, 1'b0, 64'd0, 64'd0, 1'b0},
    '{CMD_SIGNED, 64'hffff_ffff_ffff_fff9, 64'hffff_ffff_ffff_fffe, 1'b0,
      64'd0, 64'd0, 1'b0},
    '{CMD_SIGNED, 64'd0, 64'hffff_ffff_ffff_fffb, 1'b0, 64'd0, 64'd0, 1'b0},
    '{CMD_UNSIGNED, 64'h0123_4567_89ab_cdef, 64'h1_0000, 1'b0, 64'd0, 64'd0, 1'b0},
    '{CMD_UNSIGNED, 64'hfedc_ba98_7654_3210, 64'hffff_fffd, 1'b0,
      64'd0, 64'd0, 1'b0},
    '{CMD_SIGNED, MIN_S64, 64'd3, 1'b0, 64'd0, 64'd0, 1'b0}
  };

  int64_divider #(
    .WIDTH(DIV_WIDTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .dividend_i   (dividend_i),
    .divisor_i    (divisor_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quotient_o   (quotient_o),
    .remainder_o  (remainder_o),
    .div_by_zero_o(div_by_zero_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Truncating division of the low DIV_WIDTH bits. Signed mode divides the
  // magnitudes, negates the quotient when the signs differ and gives the
  // remainder the sign of the dividend. The most negative value over minus
  // one falls out of the negation as a wrap. A zero divisor yields zeros and
  // the flag.
  function automatic div_result_t predict_division(input logic is_signed,
                                                   input logic [63:0] num_in,
                                                   input logic [63:0] den_in);
    logic [63:0] width_mask;
    logic [63:0] sign_bit;
    logic [63:0] num;
    logic [63:0] den;
    logic        num_neg;
    logic        den_neg;
    div_result_t res;
    width_mask = ALL_ONES >> (64 - DIV_WIDTH);
    sign_bit = 64'd1 << (DIV_WIDTH - 1);
    num = num_in & width_mask;
    den = den_in & width_mask;
    res = '0;
    if (den == '0) begin
      res.div_by_zero = 1'b1;
      return res;
    end
    num_neg = is_signed && ((num & sign_bit) != '0);
    den_neg = is_signed && ((den & sign_bit) != '0);
    if (num_neg) num = (-num) & width_mask;
    if (den_neg) den = (-den) & width_mask;
    res.quotient = num / den;
    res.remainder = num % den;
    if (num_neg != den_neg) res.quotient = (-res.quotient) & width_mask;
    if (num_neg) res.remainder = (-res.remainder) & width_mask;
    return res;
  endfunction

  // Random operand: mostly full-range patterns or values with a random
  // number of significant bits (either sign), now and then a boundary value.
  function automatic logic [63:0] random_operand();
    logic [63:0] val;
    case ($urandom_range(0, 11))
      0: begin
        case ($urandom_range(0, 4))
          0: val = 64'd0;
          1: val = 64'd1;
          2: val = ALL_ONES;
          3: val = MIN_S64;
          default: val = MAX_S64;
        endcase
      end
      1, 2, 3, 4: val = {$urandom, $urandom};
      default: begin
        val = {$urandom, $urandom} >> $urandom_range(1, 63);
        if ($urandom_range(0, 1) == 1) val = -val;
      end
    endcase
    return val;
  endfunction

  // Presents one transaction and returns at the rising edge where it is taken.
  // Valid stays high into the next call unless that call starts with an idle
  // stretch, so valid is never dropped and raised in the same time step.
  // While idle, the payload carries junk that the block must ignore.
  task automatic send_division(input logic cmd, input logic [63:0] dividend,
                               input logic [63:0] divisor,
                               input div_result_t answer);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      cmd_i <= 1'($urandom);
      dividend_i <= {$urandom, $urandom};
      divisor_i <= {$urandom, $urandom};
      // Mostly single idle cycles; sometimes a long gap that lands somewhere
      // in the middle of the block's computation.
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(2, 90) : 1) begin
        @(negedge clk_i);
      end
    end
    cmd_i <= cmd;
    dividend_i <= dividend;
    divisor_i <= divisor;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(answer);
  endtask

  // Holds the input side off until every outstanding result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stalls out_ready_i for the chosen share of cycles. An
  // occasional long stall keeps a result parked in the output register long
  // enough that the next finished result has to wait behind it.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : 0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker: every transaction leaving the block is compared with the
  // oldest outstanding prediction.
  always @(posedge clk_i) begin
    div_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none outstanding: quotient %h remainder %h",
               quotient_o, remainder_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (quotient_o !== want.quotient) begin
          $error("quotient: expected %h, actual %h", want.quotient, quotient_o);
          mismatch_count++;
        end
        if (remainder_o !== want.remainder) begin
          $error("remainder: expected %h, actual %h", want.remainder, remainder_o);
          mismatch_count++;
        end
        if (div_by_zero_o !== want.div_by_zero) begin
          $error("div_by_zero: expected %b, actual %b", want.div_by_zero,
                 div_by_zero_o);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, corner cases, then three random phases: two that swap
  // which side idles the most, and a last one where neither side idles.
  initial begin
    corner_case_t row;
    div_result_t answer;
    logic        cmd;
    logic [63:0] dividend;
    logic [63:0] divisor;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 12;
    recv_stall_pct = 59;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = corner_cases[i];
      if (row.has_answer) begin
        answer = '{row.quotient, row.remainder, row.div_by_zero};
      end else begin
        answer = predict_division(row.cmd, row.dividend, row.divisor);
      end
      send_division(row.cmd, row.dividend, row.divisor, answer);
    end
    // The sender stops here until the corner cases have all come back.
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_stall_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        cmd = 1'($urandom);
        dividend = random_operand();
        divisor = ($urandom_range(0, 29) == 0) ? 64'd0 : random_operand();
        send_division(cmd, dividend, divisor, predict_division(cmd, dividend, divisor));
      end
      drain_results();
    end

    // Give a stray extra result time to show up before the verdict.
    repeat (2 * DIV_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("== FAIL ==");
    $finish;
  end

endmodule
